// ===== rtl/lfpe_pkg.sv =====
// shared types, constants and the line-bit encoder for the led fade pulse encoder
package lfpe_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned FrameBytes = 9;
  localparam int unsigned ColourW    = 3 * ChanW;
  localparam int unsigned FrameW     = 8 * FrameBytes;
  localparam int unsigned ByteIdxW   = $clog2(FrameBytes);
  localparam int unsigned QueueDepth = 2;

  localparam logic [ByteIdxW-1:0] LastByte = ByteIdxW'(FrameBytes - 1);

  typedef enum logic {
    KIND_FADE   = 1'b0,
    KIND_DIRECT = 1'b1
  } item_kind_t;

  // one frame waiting between the front and the back
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             at_target;
  } frame_cmd_t;

  // green, red, blue, msb first; each colour bit gives line bits 1, bit, 0,
  // line bit p lands in bit p of the frame word (byte p/8, bit p mod 8)
  function automatic logic [FrameW-1:0] encode_frame(input logic [ChanW-1:0] red,
                                                     input logic [ChanW-1:0] green,
                                                     input logic [ChanW-1:0] blue);
    logic [ColourW-1:0] grb;
    logic [FrameW-1:0]  f;
    grb = {green, red, blue};
    f   = '0;
    for (int i = 0; i < ColourW; i++) begin
      f[3*i]     = 1'b1;
      f[3*i + 1] = grb[ColourW - 1 - i];
      f[3*i + 2] = 1'b0;
    end
    return f;
  endfunction

  function automatic logic [ChanW-1:0] step_toward(input logic [ChanW-1:0] cur,
                                                   input logic [ChanW-1:0] tgt);
    logic [ChanW-1:0] res;
    if (cur < tgt) begin
      res = cur + ChanW'(1);
    end else if (cur > tgt) begin
      res = cur - ChanW'(1);
    end else begin
      res = cur;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lfpe_channels.sv =====
// valid/ready channel interfaces for colour items and encoded bytes
interface lfpe_item_if
  import lfpe_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ChanW-1:0] red_value;
  logic [ChanW-1:0] green_value;
  logic [ChanW-1:0] blue_value;

  modport source (output valid, kind, red_value, green_value, blue_value, input ready);
  modport sink   (input valid, kind, red_value, green_value, blue_value, output ready);
endinterface

interface lfpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       last_of_frame;
  logic       at_target;

  modport source (output valid, spi_byte, last_of_frame, at_target, input ready);
  modport sink   (input valid, spi_byte, last_of_frame, at_target, output ready);
endinterface

// ===== rtl/led_fade_pulse_encoder_unit.sv =====
// top level of the led fade pulse encoder: front, frame queue and byte sender
//
// channel    dir  transfer     payload
// item_in    in   colour item  kind, red_value, green_value, blue_value
// byte_out   out  frame byte   spi_byte, last_of_frame, at_target
//
// a frame is nine byte transfers, one per cycle with no stall on byte_out;
// items that give a frame are sustained at the pace of the byte sender, which takes
// one frame for each nine bytes sent; fade items already at target are taken with no frame.
// the item side keeps accepting while the frame queue has room.
// synchronous reset clears the stored colour (black), the queue and the sender.
module led_fade_pulse_encoder_unit
  import lfpe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  lfpe_item_if.sink   item_in,
  lfpe_byte_if.source byte_out
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  frame_cmd_t push_cmd, pop_cmd;

  lfpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lfpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lfpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .byte_out  (byte_out)
  );

endmodule

// ===== rtl/lfpe_front.sv =====
// front: takes colour items, applies fade steps to the stored colour, issues frames
module lfpe_front
  import lfpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lfpe_item_if.sink         item_in,
  output logic              push_valid,
  input  logic              push_ready,
  output frame_cmd_t        push_cmd
);

  logic [ChanW-1:0] cur_red, cur_green, cur_blue;
  logic [ChanW-1:0] step_red, step_green, step_blue;
  logic             is_direct, at_now, take;

  assign is_direct  = (item_kind_t'(item_in.kind) == KIND_DIRECT);
  assign at_now     = (cur_red == item_in.red_value) && (cur_green == item_in.green_value)
                      && (cur_blue == item_in.blue_value);
  assign step_red   = step_toward(cur_red, item_in.red_value);
  assign step_green = step_toward(cur_green, item_in.green_value);
  assign step_blue  = step_toward(cur_blue, item_in.blue_value);

  // ready tracks queue space; a fade already at target is taken and dropped
  assign item_in.ready = push_ready;
  assign take          = item_in.valid && push_ready;
  assign push_valid    = item_in.valid && (is_direct || !at_now);

  always_comb begin
    if (is_direct) begin
      push_cmd.red       = item_in.red_value;
      push_cmd.green     = item_in.green_value;
      push_cmd.blue      = item_in.blue_value;
      push_cmd.at_target = 1'b0;
    end else begin
      push_cmd.red       = step_red;
      push_cmd.green     = step_green;
      push_cmd.blue      = step_blue;
      push_cmd.at_target = (step_red == item_in.red_value)
                           && (step_green == item_in.green_value)
                           && (step_blue == item_in.blue_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_red   <= '0;
      cur_green <= '0;
      cur_blue  <= '0;
    end else if (take && !is_direct && !at_now) begin
      cur_red   <= step_red;
      cur_green <= step_green;
      cur_blue  <= step_blue;
    end
  end

endmodule

// ===== rtl/lfpe_queue.sv =====
// small first-in first-out queue of frame commands between front and back
module lfpe_queue
  import lfpe_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  frame_cmd_t push_cmd,
  output logic       pop_valid,
  input  logic       pop_ready,
  output frame_cmd_t pop_cmd
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);

  frame_cmd_t      slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/lfpe_back.sv =====
// back: encodes a frame and sends it out one byte per transfer
module lfpe_back
  import lfpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  frame_cmd_t pop_cmd,
  lfpe_byte_if.source byte_out
);

  logic [FrameW-1:0]   frame;
  logic [ByteIdxW-1:0] byte_idx;
  logic                active;
  logic                frame_at;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                out_last;
  logic                out_at;
  logic                advance, emit, on_last, load;

  assign advance   = !out_valid || byte_out.ready;
  assign emit      = advance && active;
  assign on_last   = (byte_idx == LastByte);
  // next frame loads as the last byte of the current one leaves
  assign load      = pop_valid && (!active || (emit && on_last));
  assign pop_ready = !active || (emit && on_last);

  assign byte_out.valid         = out_valid;
  assign byte_out.spi_byte      = out_byte;
  assign byte_out.last_of_frame = out_last;
  assign byte_out.at_target     = out_at;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        byte_idx  <= byte_idx + ByteIdxW'(1);
        if (on_last) begin
          active <= 1'b0;
        end
      end else if (advance) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        active   <= 1'b1;
        byte_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= frame[{byte_idx, 3'b000} +: 8];
      out_last <= on_last;
      out_at   <= frame_at;
    end
    if (load) begin
      frame    <= encode_frame(pop_cmd.red, pop_cmd.green, pop_cmd.blue);
      frame_at <= pop_cmd.at_target;
    end
  end

endmodule

// ===== sim/led_fade_pulse_encoder_unit_checker.sv =====
// frame checker for the led fade pulse encoder: predicts the encoded bytes and compares them
module led_fade_pulse_encoder_unit_checker
  import lfpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lfpe_item_if        item_mon,
  lfpe_byte_if        byte_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned items_seen,
  output int unsigned frames_due,
  output int unsigned bytes_checked
);

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last_of_frame;
    logic       at_target;
  } frame_byte_t;

  frame_byte_t      byte_queue[$];
  logic [ChanW-1:0] shade_red;
  logic [ChanW-1:0] shade_green;
  logic [ChanW-1:0] shade_blue;

  // three line bits per colour bit, green then red then blue, msb first
  function automatic logic [FrameW-1:0] line_code(input logic [ChanW-1:0] r,
                                                  input logic [ChanW-1:0] g,
                                                  input logic [ChanW-1:0] b);
    logic [ColourW-1:0] bits;
    logic [FrameW-1:0]  word;
    int                 pos;
    bits = {g, r, b};
    word = '0;
    pos  = 0;
    for (int i = ColourW - 1; i >= 0; i--) begin
      word[pos]     = 1'b1;
      word[pos + 1] = bits[i];
      pos += 3;
    end
    return word;
  endfunction

  function automatic logic [ChanW-1:0] nudge(input logic [ChanW-1:0] cur,
                                             input logic [ChanW-1:0] aim);
    if (cur < aim) return cur + 8'd1;
    if (cur > aim) return cur - 8'd1;
    return cur;
  endfunction

  task automatic queue_frame(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b, input logic at);
    logic [FrameW-1:0] word;
    frame_byte_t       fb;
    word = line_code(r, g, b);
    for (int k = 0; k < FrameBytes; k++) begin
      fb.spi_byte      = word[8*k +: 8];
      fb.last_of_frame = (k == FrameBytes - 1);
      fb.at_target     = at;
      byte_queue.push_back(fb);
    end
    frames_due++;
  endtask

  initial begin
    fail_count    = 0;
    pending       = 0;
    items_seen    = 0;
    frames_due    = 0;
    bytes_checked = 0;
    shade_red     = '0;
    shade_green   = '0;
    shade_blue    = '0;
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      shade_red   = '0;
      shade_green = '0;
      shade_blue  = '0;
      byte_queue.delete();
    end else begin
      // predictions go in first so a same-edge byte still meets the oldest one
      if (item_mon.valid && item_mon.ready) begin
        items_seen++;
        if (item_mon.kind == KIND_DIRECT) begin
          queue_frame(item_mon.red_value, item_mon.green_value, item_mon.blue_value, 1'b0);
        end else if (shade_red != item_mon.red_value || shade_green != item_mon.green_value ||
                     shade_blue != item_mon.blue_value) begin
          shade_red   = nudge(shade_red, item_mon.red_value);
          shade_green = nudge(shade_green, item_mon.green_value);
          shade_blue  = nudge(shade_blue, item_mon.blue_value);
          queue_frame(shade_red, shade_green, shade_blue,
                      shade_red == item_mon.red_value && shade_green == item_mon.green_value &&
                      shade_blue == item_mon.blue_value);
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        if (byte_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected byte %02h last %b at_target %b with nothing queued",
                     byte_mon.spi_byte, byte_mon.last_of_frame, byte_mon.at_target);
          end
        end else begin
          want = byte_queue.pop_front();
          if (want.spi_byte !== byte_mon.spi_byte ||
              want.last_of_frame !== byte_mon.last_of_frame ||
              want.at_target !== byte_mon.at_target) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("byte %0d: expected %02h last %b at_target %b, got %02h last %b at_target %b",
                       bytes_checked, want.spi_byte, want.last_of_frame, want.at_target,
                       byte_mon.spi_byte, byte_mon.last_of_frame, byte_mon.at_target);
            end
          end
        end
        bytes_checked++;
      end
    end
    pending = byte_queue.size();
  end

endmodule

// ===== sim/led_fade_pulse_encoder_unit_tb.sv =====
// testbench top for the led fade pulse encoder: clock, reset, stimulus and verdict
module led_fade_pulse_encoder_unit_tb;
  import lfpe_pkg::*;

  localparam int unsigned ItemTarget  = 350;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sender_quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_seen;
  int unsigned frames_due;
  int unsigned bytes_checked;

  always #1 clk = ~clk;

  lfpe_item_if item_ch ();
  lfpe_byte_if byte_ch ();

  led_fade_pulse_encoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_ch),
    .byte_out (byte_ch)
  );

  led_fade_pulse_encoder_unit_checker frame_chk (
    .clk           (clk),
    .rst           (rst),
    .item_mon      (item_ch),
    .byte_mon      (byte_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .items_seen    (items_seen),
    .frames_due    (frames_due),
    .bytes_checked (bytes_checked)
  );

  initial begin
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_FADE;
    item_ch.red_value   = '0;
    item_ch.green_value = '0;
    item_ch.blue_value  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input item_kind_t k, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.kind        <= k;
    item_ch.red_value   <= r;
    item_ch.green_value <= g;
    item_ch.blue_value  <= b;
    item_ch.valid       <= 1'b1;
    @(posedge clk);
    while (!(item_ch.valid && item_ch.ready)) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] drift(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 10)) - 5;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  task automatic send_random_direct();
    send_item(KIND_DIRECT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0]  aim_r;
    logic [7:0]  aim_g;
    logic [7:0]  aim_b;
    int unsigned pick;
    int unsigned run;
    aim_r = '0;
    aim_g = '0;
    aim_b = '0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // black after reset, so this fade is taken with no frame
    send_item(KIND_FADE, 8'h00, 8'h00, 8'h00);
    send_item(KIND_DIRECT, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_DIRECT, 8'h00, 8'h00, 8'h00);
    send_item(KIND_DIRECT, 8'hAA, 8'h55, 8'h0F);
    send_item(KIND_DIRECT, 8'h80, 8'h01, 8'hFE);
    send_item(KIND_FADE, 8'h01, 8'h00, 8'h00);
    send_item(KIND_FADE, 8'h01, 8'h00, 8'h00);
    send_item(KIND_FADE, 8'h00, 8'h02, 8'hFF);
    // direct in the middle of a fade must not disturb the stored colour
    send_item(KIND_DIRECT, 8'h12, 8'h34, 8'h56);
    send_item(KIND_FADE, 8'h00, 8'h02, 8'hFF);
    send_item(KIND_FADE, 8'hFF, 8'hFF, 8'hFF);
    send_item(KIND_FADE, 8'hFF, 8'h00, 8'h00);
    repeat (3) send_item(KIND_FADE, 8'h00, 8'h00, 8'h00);

    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 7) == 0) sender_quiet = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_random_direct();
      end else if (pick < 25) begin
        send_item(KIND_FADE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else begin
        // a run of fades toward one target, usually near the last one
        if ($urandom_range(0, 9) == 0) begin
          aim_r = 8'($urandom_range(0, 255));
          aim_g = 8'($urandom_range(0, 255));
          aim_b = 8'($urandom_range(0, 255));
        end else begin
          aim_r = drift(aim_r);
          aim_g = drift(aim_g);
          aim_b = drift(aim_b);
        end
        run = $urandom_range(1, 8);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0) send_random_direct();
          send_item(KIND_FADE, aim_r, aim_g, aim_b);
        end
      end
    end
    item_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    $display("sent %0d colour items (direct, fade steps, fades at target); %0d gave frames",
             items_seen, frames_due);
    $display("checked %0d frame bytes under random gaps and two long receiver hold-offs",
             bytes_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("led_fade_pulse_encoder_unit: match");
    end else begin
      $display("led_fade_pulse_encoder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned bytes_taken;
    logic        quiet;
    byte_ch.ready = 1'b0;
    bytes_taken   = 0;
    quiet         = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (bytes_taken % 45 == 0) quiet = ($urandom_range(0, 3) == 0);
      // long hold-offs back the frame queue up until the item side stalls
      if (bytes_taken == 180 || bytes_taken == 1800) begin
        stall = HoldCycles;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      byte_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(byte_ch.valid && byte_ch.ready)) @(posedge clk);
      @(negedge clk);
      bytes_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("led_fade_pulse_encoder_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
